// ----- rtl/olist_pkg.sv -----
// Package for the ordered list insert block: sizes, field types and status codes.
// No dependencies; used by ordered_list_insert_at_position.
package olist_pkg;
	// List capacity and the widths that follow from it
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IDX_W    = CNT_W + 1;
	localparam int CMP_W    = 8;

	// Item field types
	typedef logic [4:0]         pos_t;
	typedef logic signed [31:0] value_t;
	typedef logic [1:0]         status_t;

	// Result status codes
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_INVALID = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
endpackage

// ----- rtl/ordered_list_insert_at_position.sv -----
// Ordered list with insert at position; emits the list forward, then backward.
// Depends on olist_pkg for sizes, field types and status codes.
// The first result is registered from S_LIST, after the S_INS state that follows acceptance.
// No new item is taken until the listing or error result is done; the listing gives
// one result per cycle while out_stall allows; an error item gives a single result.
// Reset clears count and the control state; the entries hold no reset value.
module ordered_list_insert_at_position (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  olist_pkg::pos_t   position,
	input  olist_pkg::value_t item_value,
	output logic              out_valid,
	input  logic              out_stall,
	output olist_pkg::status_t status,
	output logic              direction,
	output olist_pkg::value_t listed_value,
	output logic              last
);
	import olist_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;
	localparam logic [1:0] S_ERR  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	pos_t             pos_q;
	value_t           val_q;
	status_t          err_q;
	value_t           entries_q [CAPACITY];

	logic             out_valid_q;
	status_t          status_q;
	logic             direction_q;
	value_t           listed_value_q;
	logic             last_q;

	logic             in_take;
	logic             slot_free;
	logic [IDX_W-1:0] total_m1;
	logic             list_dir;
	logic [IDX_W-1:0] list_pos;
	logic [ADDR_W-1:0] list_addr;
	logic             list_last;

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// Shared listing unit: map the result index to an entry address
	always_comb begin
		total_m1  = {count_q, 1'b0} - IDX_W'(1);
		list_dir  = (idx_q >= IDX_W'(count_q));
		list_pos  = list_dir ? (total_m1 - idx_q) : idx_q;
		list_addr = list_pos[ADDR_W-1:0];
		list_last = (idx_q == total_m1);
	end

	// Sequencer: check, insert, then list one result per free output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (CMP_W'(position) > CMP_W'(count_q)) begin
							state_q <= S_ERR;
						end else if (CMP_W'(count_q) >= CMP_W'(CAPACITY)) begin
							state_q <= S_ERR;
						end else begin
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					count_q <= count_q + CNT_W'(1);
					idx_q   <= '0;
					state_q <= S_LIST;
				end
				S_LIST: begin
					if (slot_free) begin
						idx_q <= idx_q + IDX_W'(1);
						if (list_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ERR: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the accepted item and its error code
	always_ff @(posedge clk) begin
		if (in_take) begin
			pos_q <= position;
			val_q <= item_value;
			err_q <= (CMP_W'(position) > CMP_W'(count_q)) ? ST_INVALID : ST_FULL;
		end
	end

	// Insert: move entries above the position up by one, write the new value
	always_ff @(posedge clk) begin
		if (state_q == S_INS) begin
			if (pos_q == '0) begin
				entries_q[0] <= val_q;
			end
			for (int i = 1; i < CAPACITY; i++) begin
				if (CMP_W'(i) == CMP_W'(pos_q)) begin
					entries_q[i] <= val_q;
				end else if (CMP_W'(i) > CMP_W'(pos_q) && CMP_W'(i) <= CMP_W'(count_q)) begin
					entries_q[i] <= entries_q[i-1];
				end
			end
		end
	end

	// Output register: hold until taken, reload from the listing or error path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= (state_q == S_LIST) || (state_q == S_ERR);
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (state_q == S_ERR) begin
				status_q       <= err_q;
				direction_q    <= 1'b0;
				listed_value_q <= '0;
				last_q         <= 1'b1;
			end else begin
				status_q       <= ST_OK;
				direction_q    <= list_dir;
				listed_value_q <= entries_q[list_addr];
				last_q         <= list_last;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign direction    = direction_q;
	assign listed_value = listed_value_q;
	assign last         = last_q;

	// The count never passes the capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("count above capacity");

	// An insert grows the list by exactly one
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow count by one");

	// An error result is a single forward result with a zero value
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (last_q && !direction_q && listed_value_q == '0))
		else $error("malformed error result");

	// The listing ends on a backward result
	a_last_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q && status_q == ST_OK) |-> direction_q)
		else $error("last listing result not backward");
endmodule
